[design/zres_pkg.sv]
// Shared types and constants for the zero-run escape string encoder.
// Used by zres_build, zres_emit and zero_run_escape_string_encoder.
package zres_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned IDX_W       = 2;

    localparam logic [7:0] ESC_BYTE  = 8'h00;
    localparam logic [7:0] RUN_MAX   = 8'hFF;
    localparam logic [7:0] RUN_LIMIT = 8'hFE;

    typedef logic [MAX_RESULTS-1:0][7:0] t_bytes;

    typedef struct packed {
        t_bytes           bytes;
        logic [CNT_W-1:0] cnt;
        logic             ends;
    } t_group;

endpackage

[design/zres_build.sv]
// Combinational encoder step: turns one item and the pending zero count into
// a group of up to four output bytes. Depends on zres_pkg.
module zres_build (
    input  logic [7:0]      i_data_byte,
    input  logic           i_end_marker,
    input  logic [7:0]      i_pend_cnt,
    output zres_pkg::t_group o_group,
    output logic [7:0]      o_next_cnt
);

    always_comb begin
        o_group.bytes = '0;
        o_group.cnt   = '0;
        o_group.ends  = 1'b0;
        o_next_cnt    = 8'd0;
        if (i_end_marker) begin
            o_group.ends = 1'b1;
            if (i_pend_cnt != 8'd0) begin
                o_group.bytes[0] = zres_pkg::ESC_BYTE;
                o_group.bytes[1] = i_pend_cnt;
                o_group.bytes[2] = zres_pkg::ESC_BYTE;
                o_group.bytes[3] = zres_pkg::ESC_BYTE;
                o_group.cnt      = 3'd4;
            end else begin
                o_group.bytes[0] = zres_pkg::ESC_BYTE;
                o_group.bytes[1] = zres_pkg::ESC_BYTE;
                o_group.cnt      = 3'd2;
            end
        end else if (i_data_byte == 8'd0) begin
            if (i_pend_cnt >= zres_pkg::RUN_LIMIT) begin
                o_group.bytes[0] = zres_pkg::ESC_BYTE;
                o_group.bytes[1] = zres_pkg::RUN_MAX;
                o_group.cnt      = 3'd2;
            end else begin
                o_next_cnt = i_pend_cnt + 8'd1;
            end
        end else if (i_pend_cnt != 8'd0) begin
            o_group.bytes[0] = zres_pkg::ESC_BYTE;
            o_group.bytes[1] = i_pend_cnt;
            o_group.bytes[2] = i_data_byte;
            o_group.cnt      = 3'd3;
        end else begin
            o_group.bytes[0] = i_data_byte;
            o_group.cnt      = 3'd1;
        end
    end

endmodule

[design/zres_emit.sv]
// Result register: holds one group of encoded bytes and sends them out one
// per cycle while the output is not stalled. Depends on zres_pkg.
module zres_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  zres_pkg::t_group i_group,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_string_done
);

    logic                           r_vld;
    logic [zres_pkg::IDX_W-1:0]     r_idx;
    zres_pkg::t_group               r_grp;
    logic                           last;

    assign last          = ({1'b0, r_idx} == (r_grp.cnt - 3'd1));
    assign o_free        = !r_vld || (!i_out_stall && last);
    assign o_out_valid   = r_vld;
    assign o_out_byte    = r_grp.bytes[r_idx];
    assign o_run_last    = last;
    assign o_string_done = last && r_grp.ends;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (r_vld && !i_out_stall) begin
            if (last) begin
                r_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
    end

endmodule

[design/zero_run_escape_string_encoder.sv]
// Zero-run escape string encoder: input register, pending zero count and result stage.
// Results pass from the input register through zres_build into the result register.
// Throughput: one item per cycle while the output is not stalled and each item yields
// at most one result byte; a longer item (up to 4 bytes) holds the output register to its last byte.
// Reset (synchronous, active low) empties both stages and clears the zero count.
// Depends on zres_pkg, zres_build and zres_emit.
module zero_run_escape_string_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_marker,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_string_done
);

    logic             r_in_vld;
    logic [7:0]       r_in_data;
    logic             r_in_end;
    logic [7:0]       r_pend_cnt;
    logic [7:0]       n_pend_cnt;
    zres_pkg::t_group group;
    logic             free;
    logic             adv;
    logic             load;

    zres_build u_build (
        .i_data_byte  (r_in_data),
        .i_end_marker (r_in_end),
        .i_pend_cnt   (r_pend_cnt),
        .o_group      (group),
        .o_next_cnt   (n_pend_cnt)
    );

    zres_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_group       (group),
        .o_free        (free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

    assign adv        = r_in_vld && ((group.cnt == 3'd0) || free);
    assign load       = adv && (group.cnt != 3'd0);
    assign o_in_stall = r_in_vld && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_pend_cnt <= 8'd0;
        end else begin
            if (adv) begin
                r_pend_cnt <= n_pend_cnt;
            end
            if (i_in_valid && !o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_data_byte;
            r_in_end  <= i_end_marker;
        end
    end

    a_cnt_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt != zres_pkg::RUN_MAX)
        else $error("pending zero count reached the run maximum");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_string_done) |-> o_run_last)
        else $error("string end flagged on a byte that is not the last of its item");

    a_done_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_string_done) |-> (o_out_byte == zres_pkg::ESC_BYTE))
        else $error("terminator byte is not zero");

    a_end_clears_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_end) |=> (r_pend_cnt == 8'd0))
        else $error("zero count not cleared after end of string");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for zero_run_escape_string_encoder: random and directed byte strings,
// random sender gaps and receiver stalls, results checked against an in-bench encoder model.
// Depends on zres_pkg and the encoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS   = 380;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       done;
    } t_enc_byte;

    class t_enc_scoreboard;
        t_enc_byte  encoded_q[$];
        logic [7:0] zero_run;
        int         errors;

        function new();
            zero_run = '0;
            errors   = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("%0t ERROR %s", $realtime, msg);
            errors++;
        endtask

        function void flush_run(ref t_enc_byte batch[$]);
            if (zero_run != 0) begin
                batch.push_back('{byte_val: zres_pkg::ESC_BYTE, last: 1'b0, done: 1'b0});
                batch.push_back('{byte_val: zero_run, last: 1'b0, done: 1'b0});
                zero_run = '0;
            end
        endfunction

        function void note_input(input logic [7:0] data, input logic eos);
            t_enc_byte batch[$];
            if (eos) begin
                flush_run(batch);
                batch.push_back('{byte_val: zres_pkg::ESC_BYTE, last: 1'b0, done: 1'b0});
                batch.push_back('{byte_val: zres_pkg::ESC_BYTE, last: 1'b0, done: 1'b1});
            end else if (data == zres_pkg::ESC_BYTE) begin
                if (zero_run == zres_pkg::RUN_LIMIT) begin
                    batch.push_back('{byte_val: zres_pkg::ESC_BYTE, last: 1'b0, done: 1'b0});
                    batch.push_back('{byte_val: zres_pkg::RUN_MAX, last: 1'b0, done: 1'b0});
                    zero_run = '0;
                end else begin
                    zero_run = zero_run + 8'd1;
                end
            end else begin
                flush_run(batch);
                batch.push_back('{byte_val: data, last: 1'b0, done: 1'b0});
            end
            if (batch.size() > 0) begin
                batch[batch.size()-1].last = 1'b1;
            end
            foreach (batch[i]) begin
                encoded_q.push_back(batch[i]);
            end
        endfunction

        task check_output(input logic [7:0] byte_val, input logic last, input logic done);
            t_enc_byte exp_byte;
            if (encoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte %02h", byte_val));
            end else begin
                exp_byte = encoded_q.pop_front();
                if (byte_val !== exp_byte.byte_val) begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              byte_val, exp_byte.byte_val));
                end
                if (last !== exp_byte.last) begin
                    report_mismatch($sformatf("run_last %b, expected %b", last, exp_byte.last));
                end
                if (done !== exp_byte.done) begin
                    report_mismatch($sformatf("string_done %b, expected %b",
                                              done, exp_byte.done));
                end
            end
        endtask
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_data_byte   = 8'h00;
    logic       i_end_marker  = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_string_done;

    t_enc_scoreboard sb = new();
    bit              calm = 1'b0;
    int unsigned     idle_cycles = 0;
    int unsigned     stall_hold = 0;
    int unsigned     random_sent = 0;

    zero_run_escape_string_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_end_marker  (i_end_marker),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

    always #5 i_clk = ~i_clk;

    // Monitors and watchdog sample the values that were present at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_input(i_data_byte, i_end_marker);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_output(o_out_byte, o_run_last, o_string_done);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        int unsigned pick;
        if (stall_hold > 0) begin
            stall_hold--;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                i_out_stall <= 1'b0;
                stall_hold = $urandom_range(0, 3);
            end else if (pick < 92) begin
                i_out_stall <= 1'b1;
                stall_hold = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold = $urandom_range(8, 30);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [7:0] data, input logic eos);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= data;
        i_end_marker <= eos;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random(input logic [7:0] data, input logic eos);
        send_item(data, eos);
        random_sent++;
    endtask

    task automatic wait_drained();
        while (sb.encoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_string();
        int unsigned len;
        int unsigned pick;
        calm = ($urandom_range(0, 5) == 0);
        len  = $urandom_range(0, 10);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_random(8'h00, 1'b0);
            end else if (pick < 45) begin
                repeat ($urandom_range(2, 8)) send_random(8'h00, 1'b0);
            end else begin
                send_random(8'($urandom_range(1, 255)), 1'b0);
            end
        end
        if ($urandom_range(0, 99) < 85) begin
            send_random(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(8'h01, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h7E, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h5A, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);

        // A run long enough to hit the 255 count, with a short remainder.
        repeat (255 + $urandom_range(0, 20)) send_random(8'h00, 1'b0);
        send_random(8'($urandom_range(0, 255)), 1'b1);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();

        while (random_sent < RANDOM_ITEMS) begin
            send_random_string();
        end
        send_random(8'($urandom_range(0, 255)), 1'b1);
        i_in_valid <= 1'b0;
        calm = 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.encoded_q.size() != 0) begin
            sb.report_mismatch($sformatf("%0d expected bytes never arrived",
                                         sb.encoded_q.size()));
        end
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
